// ----- hdl/hned_pkg.sv -----
// Shared types, codes and helpers for the HMM next-emission distribution block.
// Used by every module of the block; depends on nothing.
package hned_pkg;

    // default store dimensions
    localparam int DEF_MAX_STATES  = 8;
    localparam int DEF_MAX_SYMBOLS = 8;

    // fixed field widths
    localparam int CNT_W   = 4;
    localparam int PROB_W  = 16;
    localparam int PROD_W  = 2 * PROB_W;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    // request operation codes
    localparam logic [1:0] OP_LOAD_TRANS = 2'd0;
    localparam logic [1:0] OP_LOAD_EMIS  = 2'd1;
    localparam logic [1:0] OP_LOAD_INIT  = 2'd2;
    localparam logic [1:0] OP_COMPUTE    = 2'd3;

    // register indexes (paddr bit 2)
    localparam logic REG_NUM_STATES  = 1'b0;
    localparam logic REG_NUM_SYMBOLS = 1'b1;

    // request payload
    typedef struct packed {
        logic [1:0]        operation;
        logic [2:0]        row;
        logic [2:0]        col;
        logic [PROB_W-1:0] value;
    } hned_req_t;

    // result payload
    typedef struct packed {
        logic [2:0]        symbol_index;
        logic [PROB_W-1:0] probability;
        logic              last;
    } hned_result_t;

    // control tag that follows each product down the mac pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last_dot;
        logic emit;
        logic last_out;
    } hned_tag_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_NEXT  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_FLUSH = 5'b10000
    } hned_state_t;

    // index width for a store of n entries, at least one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ----- hdl/hned_store.sv -----
// Model stores: transition, emission, initial and next-state memories.
// Depends on hned_pkg; written by load requests and the mac, read by the mac at sequencer addresses.
module hned_store #(
    parameter int MAX_STATES  = hned_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS = hned_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                                              clk,
    input  logic                                              load_en,
    input  hned_pkg::hned_req_t                               request,
    input  logic [hned_pkg::idx_w(MAX_STATES)-1:0]            rd_i,
    input  logic [hned_pkg::idx_w(hned_pkg::idx_w(MAX_STATES) > hned_pkg::idx_w(MAX_SYMBOLS)
                  ? MAX_STATES : MAX_SYMBOLS)-1:0]            rd_j,
    input  logic                                              nwr_en,
    input  logic [hned_pkg::idx_w(MAX_STATES)-1:0]            nwr_addr,
    input  logic [hned_pkg::PROB_W-1:0]                       nwr_data,
    output logic [hned_pkg::PROB_W-1:0]                       init_q,
    output logic [hned_pkg::PROB_W-1:0]                       next_q,
    output logic [hned_pkg::PROB_W-1:0]                       trans_q,
    output logic [hned_pkg::PROB_W-1:0]                       emis_q
);
    import hned_pkg::*;

    localparam int SW      = idx_w(MAX_STATES);
    localparam int T_DEPTH = MAX_STATES * MAX_STATES;
    localparam int E_DEPTH = MAX_STATES * MAX_SYMBOLS;
    localparam int TAW     = idx_w(T_DEPTH);
    localparam int EAW     = idx_w(E_DEPTH);

    logic [PROB_W-1:0] trans_mem [T_DEPTH];
    logic [PROB_W-1:0] emis_mem  [E_DEPTH];
    logic [PROB_W-1:0] init_mem  [MAX_STATES];
    logic [PROB_W-1:0] next_mem  [MAX_STATES];

    logic           row_ok;
    logic           trans_we;
    logic           emis_we;
    logic           init_we;
    logic [TAW-1:0] trans_waddr;
    logic [EAW-1:0] emis_waddr;
    logic [SW-1:0]  init_waddr;
    logic [TAW-1:0] trans_raddr;
    logic [EAW-1:0] emis_raddr;

    // load decode, out-of-range entries are dropped
    always_comb
    begin
        row_ok      = 32'(request.row) < MAX_STATES;
        trans_we    = load_en && (request.operation == OP_LOAD_TRANS) && row_ok
                      && (32'(request.col) < MAX_STATES);
        emis_we     = load_en && (request.operation == OP_LOAD_EMIS) && row_ok
                      && (32'(request.col) < MAX_SYMBOLS);
        init_we     = load_en && (request.operation == OP_LOAD_INIT) && row_ok;
        trans_waddr = TAW'(32'(request.row) * MAX_STATES + 32'(request.col));
        emis_waddr  = EAW'(32'(request.row) * MAX_SYMBOLS + 32'(request.col));
        init_waddr  = SW'(request.row);
        trans_raddr = TAW'(32'(rd_i) * MAX_STATES + 32'(rd_j));
        emis_raddr  = EAW'(32'(rd_i) * MAX_SYMBOLS + 32'(rd_j));
    end

    // transition matrix
    always_ff @(posedge clk)
    begin
        if (trans_we)
        begin
            trans_mem[trans_waddr] <= request.value;
        end
        trans_q <= trans_mem[trans_raddr];
    end

    // emission matrix
    always_ff @(posedge clk)
    begin
        if (emis_we)
        begin
            emis_mem[emis_waddr] <= request.value;
        end
        emis_q <= emis_mem[emis_raddr];
    end

    // initial vector
    always_ff @(posedge clk)
    begin
        if (init_we)
        begin
            init_mem[init_waddr] <= request.value;
        end
        init_q <= init_mem[rd_i];
    end

    // next-state vector, written by the mac
    always_ff @(posedge clk)
    begin
        if (nwr_en)
        begin
            next_mem[nwr_addr] <= nwr_data;
        end
        next_q <= next_mem[rd_i];
    end

endmodule

// ----- hdl/hned_mac.sv -----
// Shared multiply-accumulate unit with saturation to Q0.16.
// Depends on hned_pkg; fed by hned_seq and hned_store.
module hned_mac #(
    parameter int MAX_STATES  = hned_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS = hned_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  hned_pkg::hned_tag_t                               tag0,
    input  logic [hned_pkg::idx_w(hned_pkg::idx_w(MAX_STATES) > hned_pkg::idx_w(MAX_SYMBOLS)
                  ? MAX_STATES : MAX_SYMBOLS)-1:0]            j0,
    input  logic [hned_pkg::PROB_W-1:0]                       init_q,
    input  logic [hned_pkg::PROB_W-1:0]                       next_q,
    input  logic [hned_pkg::PROB_W-1:0]                       trans_q,
    input  logic [hned_pkg::PROB_W-1:0]                       emis_q,
    output logic                                              pipe_busy,
    output logic                                              nwr_en,
    output logic [hned_pkg::idx_w(MAX_STATES)-1:0]            nwr_addr,
    output logic [hned_pkg::PROB_W-1:0]                       nwr_data,
    output logic                                              result_valid,
    output hned_pkg::hned_result_t                            result
);
    import hned_pkg::*;

    localparam int SW = idx_w(MAX_STATES);
    localparam int KW = idx_w(MAX_SYMBOLS);
    localparam int JW = idx_w((SW > KW) ? MAX_STATES : MAX_SYMBOLS);
    localparam int AW = PROD_W + SW;

    hned_tag_t         tag1_reg, tag2_reg, tag3_reg;
    logic [JW-1:0]     j1_reg, j2_reg, j3_reg;
    logic [PROB_W-1:0] op_a, op_b;
    logic [PROD_W-1:0] prod_reg;
    logic [AW-1:0]     acc_reg;
    logic [AW-1:0]     acc_next;
    logic [PROB_W-1:0] sat;
    logic              out_valid_reg;
    hned_result_t      result_reg;

    // operand select, memory data lines up with stage 1
    always_comb
    begin
        op_a = tag1_reg.emit ? next_q : init_q;
        op_b = tag1_reg.emit ? emis_q : trans_q;
    end

    // accumulate, restarting on the first term of each dot product
    always_comb
    begin
        acc_next = tag2_reg.first ? AW'(prod_reg) : acc_reg + AW'(prod_reg);
    end

    // drop the low 16 bits and clamp
    always_comb
    begin
        sat = (|acc_reg[AW-1:PROD_W]) ? {PROB_W{1'b1}} : acc_reg[PROD_W-1:PROB_W];
    end

    // control tags down the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            tag3_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tag1_reg      <= tag0;
            tag2_reg      <= tag1_reg;
            tag3_reg      <= tag2_reg;
            out_valid_reg <= tag3_reg.valid && tag3_reg.last_dot && tag3_reg.emit;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        j1_reg   <= j0;
        j2_reg   <= j1_reg;
        j3_reg   <= j2_reg;
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        if (tag2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        result_reg.symbol_index <= 3'(j3_reg);
        result_reg.probability  <= sat;
        result_reg.last         <= tag3_reg.last_out;
    end

    // next-state write back at the end of each first-phase dot product
    assign nwr_en   = tag3_reg.valid && tag3_reg.last_dot && !tag3_reg.emit;
    assign nwr_addr = SW'(j3_reg);
    assign nwr_data = sat;

    assign pipe_busy    = tag1_reg.valid || tag2_reg.valid || tag3_reg.valid;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

// ----- hdl/hned_seq.sv -----
// Sequencer: walks both matrix-vector products through the shared mac.
// Depends on hned_pkg; drives hned_store read addresses and hned_mac tags.
module hned_seq #(
    parameter int MAX_STATES  = hned_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS = hned_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              compute_go,
    input  logic [hned_pkg::CNT_W-1:0]                        num_states,
    input  logic [hned_pkg::CNT_W-1:0]                        num_symbols,
    input  logic                                              pipe_busy,
    output logic                                              busy,
    output hned_pkg::hned_tag_t                               tag0,
    output logic [hned_pkg::idx_w(MAX_STATES)-1:0]            rd_i,
    output logic [hned_pkg::idx_w(hned_pkg::idx_w(MAX_STATES) > hned_pkg::idx_w(MAX_SYMBOLS)
                  ? MAX_STATES : MAX_SYMBOLS)-1:0]            rd_j
);
    import hned_pkg::*;

    localparam int SW  = idx_w(MAX_STATES);
    localparam int KW  = idx_w(MAX_SYMBOLS);
    localparam int JW  = idx_w((SW > KW) ? MAX_STATES : MAX_SYMBOLS);
    localparam int CSW = $clog2(MAX_STATES + 1);
    localparam int CKW = $clog2(MAX_SYMBOLS + 1);

    hned_state_t    state_reg, state_next;
    logic [SW-1:0]  i_reg, i_next;
    logic [JW-1:0]  j_reg, j_next;
    logic [CSW-1:0] ns_c;
    logic [CKW-1:0] nk_c;
    logic [SW-1:0]  last_s;
    logic [KW-1:0]  last_k;
    logic           i_last;
    logic           j_last;

    // clamp the counts to 1..MAX
    always_comb
    begin
        if (num_states == '0)
        begin
            ns_c = CSW'(1);
        end
        else if (32'(num_states) > MAX_STATES)
        begin
            ns_c = CSW'(MAX_STATES);
        end
        else
        begin
            ns_c = CSW'(num_states);
        end
        if (num_symbols == '0)
        begin
            nk_c = CKW'(1);
        end
        else if (32'(num_symbols) > MAX_SYMBOLS)
        begin
            nk_c = CKW'(MAX_SYMBOLS);
        end
        else
        begin
            nk_c = CKW'(num_symbols);
        end
        last_s = SW'(ns_c - CSW'(1));
        last_k = KW'(nk_c - CKW'(1));
    end

    // loop ends
    always_comb
    begin
        i_last = (i_reg == last_s);
        j_last = state_reg[4:0] == ST_EMIT ? (j_reg == JW'(last_k)) : (j_reg == JW'(last_s));
    end

    // state and counter update
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        case (state_reg)
            ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                if (compute_go)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT, ST_EMIT:
            begin
                if (i_last)
                begin
                    i_next = '0;
                    if (j_last)
                    begin
                        j_next     = '0;
                        state_next = (state_reg == ST_NEXT) ? ST_DRAIN : ST_FLUSH;
                    end
                    else
                    begin
                        j_next = j_reg + JW'(1);
                    end
                end
                else
                begin
                    i_next = i_reg + SW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_FLUSH:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // issue one product per cycle in both run states
    always_comb
    begin
        tag0.valid    = (state_reg == ST_NEXT) || (state_reg == ST_EMIT);
        tag0.first    = (i_reg == '0);
        tag0.last_dot = i_last;
        tag0.emit     = (state_reg == ST_EMIT);
        tag0.last_out = j_last;
    end

    assign busy = (state_reg != ST_IDLE);
    assign rd_i = i_reg;
    assign rd_j = j_reg;

endmodule

// ----- hdl/hmm_next_emission_distribution.sv -----
// Top level of the HMM next-emission distribution block: config registers and wiring.
// Depends on hned_pkg, hned_store, hned_mac and hned_seq.
//
// Load requests (transition, emission or initial entry) are taken while busy is low and busy stays
// low. A compute request raises busy and walks ns*ns products for the next-state vector and
// ns*nk products for the emission step through one shared 16x16 multiply-accumulate unit, one
// product per cycle, with a pipeline drain between the two phases; ns and nk are the clamped
// counts. The nk results leave one at a time, each on result for a single cycle under
// result_valid, in symbol order, the final one with last set; the receiver must take them as
// they come. busy drops the cycle after the final result. Counts must be written through the
// APB port only while busy is low; the block itself does not enforce this.
module hmm_next_emission_distribution #(
    parameter int MAX_STATES  = hned_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS = hned_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  hned_pkg::hned_req_t           request,
    output logic                          result_valid,
    output hned_pkg::hned_result_t        result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hned_pkg::PADDR_W-1:0]  paddr,
    input  logic [hned_pkg::APB_W-1:0]    pwdata,
    output logic [hned_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);
    import hned_pkg::*;

    localparam int SW = idx_w(MAX_STATES);
    localparam int KW = idx_w(MAX_SYMBOLS);
    localparam int JW = idx_w((SW > KW) ? MAX_STATES : MAX_SYMBOLS);

    logic [CNT_W-1:0]  num_states_reg;
    logic [CNT_W-1:0]  num_symbols_reg;
    logic              cfg_wr;
    logic              accept;
    logic              compute_go;
    logic              pipe_busy;
    hned_tag_t         tag0;
    logic [SW-1:0]     rd_i;
    logic [JW-1:0]     rd_j;
    logic              nwr_en;
    logic [SW-1:0]     nwr_addr;
    logic [PROB_W-1:0] nwr_data;
    logic [PROB_W-1:0] init_q, next_q, trans_q, emis_q;

    // request handshake
    assign accept     = start && !busy;
    assign compute_go = accept && (request.operation == OP_COMPUTE);

    // config register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg  <= CNT_W'(1);
            num_symbols_reg <= CNT_W'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_NUM_STATES:  num_states_reg  <= pwdata[CNT_W-1:0];
                REG_NUM_SYMBOLS: num_symbols_reg <= pwdata[CNT_W-1:0];
                default:         num_states_reg  <= num_states_reg;
            endcase
        end
    end

    // config register reads
    always_comb
    begin
        case (paddr[2])
            REG_NUM_STATES:  prdata = APB_W'(num_states_reg);
            REG_NUM_SYMBOLS: prdata = APB_W'(num_symbols_reg);
            default:         prdata = '0;
        endcase
    end

    hned_seq #(
        .MAX_STATES  (MAX_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .compute_go  (compute_go),
        .num_states  (num_states_reg),
        .num_symbols (num_symbols_reg),
        .pipe_busy   (pipe_busy),
        .busy        (busy),
        .tag0        (tag0),
        .rd_i        (rd_i),
        .rd_j        (rd_j)
    );

    hned_store #(
        .MAX_STATES  (MAX_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_store (
        .clk      (clk),
        .load_en  (accept),
        .request  (request),
        .rd_i     (rd_i),
        .rd_j     (rd_j),
        .nwr_en   (nwr_en),
        .nwr_addr (nwr_addr),
        .nwr_data (nwr_data),
        .init_q   (init_q),
        .next_q   (next_q),
        .trans_q  (trans_q),
        .emis_q   (emis_q)
    );

    hned_mac #(
        .MAX_STATES  (MAX_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .tag0         (tag0),
        .j0           (rd_j),
        .init_q       (init_q),
        .next_q       (next_q),
        .trans_q      (trans_q),
        .emis_q       (emis_q),
        .pipe_busy    (pipe_busy),
        .nwr_en       (nwr_en),
        .nwr_addr     (nwr_addr),
        .nwr_data     (nwr_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- hdl/hned_checker.sv -----
// Port-level checks for the HMM next-emission distribution block, bound to the top level.
// Depends on hned_pkg and hmm_next_emission_distribution.
module hned_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  hned_pkg::hned_req_t    request,
    input  logic                   result_valid,
    input  hned_pkg::hned_result_t result
);
    import hned_pkg::*;

    // results only while a compute is running
    a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside a compute");

    // a load leaves the block free
    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.operation != OP_COMPUTE) |=> !busy)
        else $error("load request raised busy");

    // a compute occupies the block
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.operation == OP_COMPUTE) |=> busy)
        else $error("compute request did not raise busy");

    // busy ends right after the final result
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(result_valid && result.last))
        else $error("busy dropped without a final result");

endmodule

bind hmm_next_emission_distribution hned_checker u_hned_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
);
